FILE: src/sssenc_pkg.sv
`default_nettype none
package sssenc_pkg;

	localparam int VALUE_W     = 32;
	localparam int SCAN_W      = 16;
	localparam int DOT_MASK_W  = 6;
	localparam int DIGITS_DEF  = 6;
	// Decimal digits needed for the largest non-negative 32-bit value.
	localparam int MAX_DEC     = 10;
	localparam int QUEUE_DEPTH = 2;

	// Segment patterns for 0..9, gfedcba in bits 6..0.
	localparam logic [7:0] SEG_TABLE [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27, 8'h7F, 8'h6F
	};

	function automatic longint unsigned pow10(input int n);
		longint unsigned m;
		m = 64'd1;
		for (int i = 0; i < n; i++) begin
			m = m * 64'd10;
		end
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: src/sssenc_front.sv
`default_nettype none
module sssenc_front
	import sssenc_pkg::*;
#(
	parameter int DIGITS = DIGITS_DEF,
	localparam int REM_W = $clog2(pow10(DIGITS))
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic signed [VALUE_W-1:0] value,
	output logic                           out_valid,
	input  wire logic                      out_full,
	output logic [REM_W-1:0]               out_rem,
	output logic                           out_blank
);

	// One stage per decimal digit above the shown ones.
	localparam int NS = MAX_DEC - DIGITS;

	logic [VALUE_W-2:0] rem_s [NS];
	logic               neg_s [NS];
	logic               vld_s [NS];

	logic [VALUE_W-2:0] rem_in  [NS];
	logic [VALUE_W-2:0] rem_out [NS];
	logic               neg_in  [NS];
	logic               vld_in  [NS];
	logic               advance;

	// Hold the whole strip pipeline only when its tail cannot drain.
	assign advance   = !(vld_s[NS-1] && out_full);
	assign full      = !advance;
	assign out_valid = vld_s[NS-1];
	assign out_rem   = rem_s[NS-1][REM_W-1:0];
	assign out_blank = neg_s[NS-1];

	for (genvar i = 0; i < NS; i++) begin : g_stage
		localparam int K = MAX_DEC - 1 - i;

		if (i == 0) begin : g_head
			assign rem_in[i] = value[VALUE_W-2:0];
			assign neg_in[i] = value[VALUE_W-1];
			assign vld_in[i] = push;
		end else begin : g_body
			assign rem_in[i] = rem_s[i-1];
			assign neg_in[i] = neg_s[i-1];
			assign vld_in[i] = vld_s[i-1];
		end

		// Drop the multiples of ten to the K at this stage.
		always_comb begin
			rem_out[i] = rem_in[i];
			for (int d = 1; d <= 9; d++) begin
				if (64'(rem_in[i]) >= 64'(d) * pow10(K)) begin
					rem_out[i] = rem_in[i] - (VALUE_W-1)'(64'(d) * pow10(K));
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (advance) begin
				vld_s[i] <= vld_in[i];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[i] <= rem_out[i];
				neg_s[i] <= neg_in[i];
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/sssenc_queue.sv
`default_nettype none
module sssenc_queue
	import sssenc_pkg::*;
#(
	parameter int W     = 21,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [W-1:0] wr_data,
	output logic              q_full,
	input  wire logic         rd_en,
	output logic              q_valid,
	output logic [W-1:0]      rd_data
);

	logic [W-1:0]     entry_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign rd_data = entry_q[rptr_q];
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

FILE: src/sssenc_back.sv
`default_nettype none
module sssenc_back
	import sssenc_pkg::*;
#(
	parameter int DIGITS = DIGITS_DEF,
	localparam int REM_W = $clog2(pow10(DIGITS)),
	localparam int PW    = $clog2(DIGITS + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire logic [REM_W-1:0]      q_rem,
	input  wire logic                  q_blank,
	output logic                       q_pop,
	input  wire logic [DOT_MASK_W-1:0] dot_mask,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [SCAN_W-1:0]          scan_word,
	output logic                       last
);

	localparam longint unsigned TOP_P = pow10(DIGITS - 1);

	logic              busy_q;
	logic [PW-1:0]     pos_q;
	logic [REM_W-1:0]  rem_q;
	logic              blank_q;
	logic              oval_q;
	logic [SCAN_W-1:0] word_q;
	logic              last_q;

	logic              slot_free;
	logic              emit;
	logic              at_end;
	logic [3:0]        digit;
	logic [REM_W-1:0]  rem_sub;
	logic [REM_W+3:0]  rem_x10;
	logic [REM_W-1:0]  rem_next;
	logic [3:0]        pos4;
	logic [7:0]        dot_ext;
	logic [7:0]        sel;
	logic              dot;
	logic [6:0]        seg;
	logic [SCAN_W-1:0] digit_word;

	assign slot_free = !oval_q || pop;
	assign emit      = busy_q && slot_free;
	assign at_end    = (pos_q == PW'(DIGITS));
	assign q_pop     = q_valid && (!busy_q || (emit && at_end));

	assign empty     = !oval_q;
	assign scan_word = word_q;
	assign last      = last_q;

	// Leading digit of the remainder, then shift the rest up one decade.
	always_comb begin
		digit   = 4'd0;
		rem_sub = rem_q;
		for (int d = 1; d <= 9; d++) begin
			if (64'(rem_q) >= 64'(d) * TOP_P) begin
				digit   = 4'(d);
				rem_sub = rem_q - REM_W'(64'(d) * TOP_P);
			end
		end
		rem_x10  = ({4'b0, rem_sub} << 3) + ({4'b0, rem_sub} << 1);
		rem_next = rem_x10[REM_W-1:0];
	end

	assign pos4       = 4'(pos_q);
	assign dot_ext    = 8'(dot_mask);
	assign dot        = (pos4 < 4'(DOT_MASK_W)) && dot_ext[pos4[2:0]];
	assign sel        = ~(8'd1 << pos4[2:0]);
	assign seg        = blank_q ? 7'd0 : SEG_TABLE[digit][6:0];
	assign digit_word = {sel, dot, seg};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			oval_q <= 1'b0;
		end else begin
			if (emit) begin
				oval_q <= 1'b1;
			end else if (pop) begin
				oval_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (emit && at_end) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rem_q   <= q_rem;
			blank_q <= q_blank;
		end else if (emit && !at_end) begin
			rem_q <= rem_next;
		end
		if (emit) begin
			word_q <= at_end ? '0 : digit_word;
			last_q <= at_end;
		end
	end

endmodule
`default_nettype wire

FILE: src/seven_segment_scan_encoder.sv
`default_nettype none
// Seven-segment scan encoder. Push a 32-bit two's complement value; the block
// answers with DIGITS + 1 scan words (7 at the default of six digits): one per
// digit position, most significant first, then a closing all-zero word with
// last set. Each digit word carries the active-low digit select in bits 15..8,
// the decimal point from dot_mask in bit 7 and the segment pattern in bits
// 6..0. A negative value blanks the segments but keeps select and dot; values
// at or above ten to the DIGITS show only their low DIGITS decimal digits.
// The word emitter sets the sustained item rate; it produces one scan word per
// cycle while the output is not stalled. A new item can be pushed every cycle
// until the strip pipeline and its two-entry queue fill; each value passes the
// strip stages and the queue before the emitter. Write dot_mask through the
// cfg channel only while no item is in flight.
module seven_segment_scan_encoder
	import sssenc_pkg::*;
#(
	parameter int DIGITS = DIGITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// input queue side
	input  wire logic                      push,
	output logic                           full,
	input  wire logic signed [VALUE_W-1:0] value,
	// result queue side
	output logic                           empty,
	input  wire logic                      pop,
	output logic [SCAN_W-1:0]              scan_word,
	output logic                           last,
	// dot mask write channel
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [DOT_MASK_W-1:0]     cfg_data
);

	localparam int REM_W = $clog2(pow10(DIGITS));

	logic [DOT_MASK_W-1:0] dot_mask_q;

	// front to queue
	logic             f_valid;
	logic [REM_W-1:0] f_rem;
	logic             f_blank;
	logic             q_full;

	// queue to back
	logic             q_valid;
	logic [REM_W:0]   q_data;
	logic             q_pop;

	// The register is always ready; take a write whenever it is offered.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			dot_mask_q <= cfg_data;
		end
	end

	// Front: accept the value, flag negatives and strip the decades above
	// the shown ones, one decade per stage.
	sssenc_front #(
		.DIGITS(DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.value    (value),
		.out_valid(f_valid),
		.out_full (q_full),
		.out_rem  (f_rem),
		.out_blank(f_blank)
	);

	// Short queue of reduced values so front and back stall independently.
	sssenc_queue #(
		.W    (REM_W + 1),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (f_valid),
		.wr_data({f_blank, f_rem}),
		.q_full (q_full),
		.rd_en  (q_pop),
		.q_valid(q_valid),
		.rd_data(q_data)
	);

	// Back: peel one decimal digit per cycle while the output slot is free and emit its
	// scan word, then the closing word; load the next item on the same cycle as the close.
	sssenc_back #(
		.DIGITS(DIGITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_rem    (q_data[REM_W-1:0]),
		.q_blank  (q_data[REM_W]),
		.q_pop    (q_pop),
		.dot_mask (dot_mask_q),
		.empty    (empty),
		.pop      (pop),
		.scan_word(scan_word),
		.last     (last)
	);

endmodule
`default_nettype wire

FILE: sim/seven_segment_scan_encoder_tb.sv
module seven_segment_scan_encoder_tb;
	import sssenc_pkg::*;

	localparam int          NUM_DIGITS  = DIGITS_DEF;
	localparam logic [31:0] MODULUS     = 32'd1_000_000;
	localparam int          CYCLE_LIMIT = 200_000;
	localparam int          HOLD_CYCLES = 300;
	localparam int          HOLD_AFTER  = 80;
	localparam int          BATCH_SIZE  = 26;

	// One scan word as it leaves the block.
	typedef struct packed {
		logic [SCAN_W-1:0] word;
		logic              last;
	} scan_item_t;

	// Segment patterns, gfedcba, for digits 0..9.
	localparam logic [6:0] DIGIT_SEGS [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h27, 7'h7F, 7'h6F
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      push = 1'b0;
	logic                      full;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic [SCAN_W-1:0]         scan_word;
	logic                      last;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [DOT_MASK_W-1:0]     cfg_data = '0;

	logic signed [VALUE_W-1:0] pending_values [$];
	scan_item_t                expected_words [$];
	logic [DOT_MASK_W-1:0]     dot_mask_shadow = '0;

	int cycle_count   = 0;
	int values_taken  = 0;
	int words_checked = 0;
	int mask_writes   = 0;
	int full_stalls   = 0;
	int fail_count    = 0;
	int idle_pct      = 6;
	int hold_left     = 0;
	bit hold_done     = 1'b0;

	seven_segment_scan_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.scan_word (scan_word),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Expand one displayed number into its digit words plus the closing word.
	// A negative number blanks the segments but keeps select and dot.
	function automatic void predict_scan_words(input logic signed [VALUE_W-1:0] num,
			input logic [DOT_MASK_W-1:0] mask);
		logic [31:0] rest;
		logic [3:0]  digit [NUM_DIGITS];
		logic [7:0]  select;
		logic [6:0]  segs;
		logic        dot;
		scan_item_t  item;
		rest = num % MODULUS;
		for (int p = NUM_DIGITS - 1; p >= 0; p--) begin
			digit[p] = 4'(rest % 10);
			rest = rest / 10;
		end
		for (int p = 0; p < NUM_DIGITS; p++) begin
			select = ~(8'b1 << (p % 8));
			segs = num[VALUE_W-1] ? 7'h00 : DIGIT_SEGS[digit[p]];
			dot = (p < DOT_MASK_W) ? mask[p] : 1'b0;
			item.word = {select, dot, segs};
			item.last = 1'b0;
			expected_words.push_back(item);
		end
		item.word = '0;
		item.last = 1'b1;
		expected_words.push_back(item);
	endfunction

	// Mix of blanking values, in-range numbers, numbers around multiples of the
	// modulus and the full positive range.
	function automatic logic signed [VALUE_W-1:0] random_value();
		int unsigned pick;
		logic [31:0] r;
		pick = $urandom_range(99);
		r = $urandom;
		if (pick < 4)
			return -1;
		else if (pick < 12)
			return {1'b1, r[30:0]};
		else if (pick < 45)
			return r % MODULUS;
		else if (pick < 60)
			return MODULUS * $urandom_range(2147) + $urandom_range(2) - 1;
		else
			return {1'b0, r[30:0]};
	endfunction

	// Drive the next pending item; hold push low on a random idle cycle.
	always @(negedge clk) begin
		if (pending_values.size() > 0 && $urandom_range(99) >= idle_pct) begin
			push <= 1'b1;
			value <= pending_values[0];
		end else begin
			push <= 1'b0;
			value <= $urandom;
		end
	end

	// Pop results, with random idles and one long hold-off that lets the
	// block fill up while the driver keeps pushing.
	always @(negedge clk) begin
		if (!hold_done && values_taken >= HOLD_AFTER) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= idle_pct);
		end
	end

	// Sample all handshakes at the rising edge: track the mask, predict on each
	// accepted item, check each popped word against the oldest expectation.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end else if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				dot_mask_shadow = cfg_data;
				mask_writes++;
			end
			if (push && full)
				full_stalls++;
			if (push && !full) begin
				predict_scan_words(value, dot_mask_shadow);
				void'(pending_values.pop_front());
				values_taken++;
			end
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$error("scan_word: no word expected, got %h (last %b)", scan_word, last);
					fail_count++;
				end else begin
					scan_item_t want;
					want = expected_words.pop_front();
					if (scan_word !== want.word) begin
						$error("scan_word: expected %h, got %h", want.word, scan_word);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %b, got %b", want.last, last);
						fail_count++;
					end
				end
				words_checked++;
			end
		end
	end

	// Block until every pushed item is taken and every word has come back.
	task automatic wait_drained();
		while (pending_values.size() != 0 || expected_words.size() != 0)
			@(posedge clk);
	endtask

	// Change the dot mask only while nothing is in flight.
	task automatic write_dot_mask(input logic [DOT_MASK_W-1:0] mask);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mask;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic signed [VALUE_W-1:0] directed_a [13];
		logic signed [VALUE_W-1:0] directed_b [12];
		logic [DOT_MASK_W-1:0]     batch_masks [7];
		directed_a = '{32'sd0, -32'sd1, 32'sh7FFF_FFFF, 32'sd999_999, 32'sd1_000_000,
			32'sd123_456, 32'sd789_012, 32'sh8000_0000, 32'sd1, 32'sd100_000,
			32'sd1_000_001, 32'sd999_999_999, -32'sd5};
		directed_b = '{32'sd0, -32'sd1, 32'sd654_321, 32'sd345_678, 32'sd888_888,
			32'sh7FFF_FFFF, 32'sd2_000_000, 32'sd10, 32'sd999_999, 32'shFFFF_FFFE,
			32'sd90_909, 32'sd1_234_567};
		batch_masks = '{6'h15, 6'h2A, 6'h00, 6'h00, 6'h00, 6'h3F, 6'h00};
		batch_masks[3] = 6'($urandom);
		batch_masks[4] = 6'($urandom);
		batch_masks[6] = 6'($urandom);

		// Hold reset, then release away from the clock edge.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed values under the reset mask of zero.
		foreach (directed_a[i])
			pending_values.push_back(directed_a[i]);

		// Same kind of corner values with every dot lit.
		write_dot_mask(6'h3F);
		foreach (directed_b[i])
			pending_values.push_back(directed_b[i]);

		// Random batches, each under its own mask. The batch where the
		// receiver holds off falls in the third one; the fourth runs with no
		// idling on either side.
		foreach (batch_masks[b]) begin
			write_dot_mask(batch_masks[b]);
			idle_pct = (b == 3) ? 0 : 6;
			repeat (BATCH_SIZE)
				pending_values.push_back(random_value());
		end

		wait_drained();
		repeat (20) @(posedge clk);

		$display("Covered %0d values (%0d scan words) across %0d dot-mask writes,",
			values_taken, words_checked, mask_writes);
		$display("with blanking, wrap past one million and %0d cycles of input stalled.",
			full_stalls);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
src/sssenc_pkg.sv
src/sssenc_front.sv
src/sssenc_queue.sv
src/sssenc_back.sv
src/seven_segment_scan_encoder.sv
sim/seven_segment_scan_encoder_tb.sv
